// File: hw/rtl/knca_pkg.sv
// Shared types, widths, codes and helpers of the k-means nearest-centroid assignment unit.
package knca_pkg;

    localparam int IDX_W   = 4;
    localparam int CIDX_W  = 5;
    localparam int CFG_W   = 5;
    localparam int VAL_W   = 32;
    localparam int DIFF_W  = 34;
    localparam int SQ_IN_W = 20;
    localparam int DIST_W  = 40;
    localparam int SUM_W   = 56;
    localparam int CNT_W   = 32;
    localparam int OUT_W   = 168;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_FEATURE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_REPORT  = 2'd3
    } t_op;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic REG_CENTROID_COUNT = 1'b0;
    localparam logic REG_FEATURE_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUT,
        ST_REP
    } t_state;

    // feature word travelling down the cell row
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             final_feat;
        logic [IDX_W-1:0] fi;
        logic [VAL_W-1:0] value;
    } t_tok;

    // running nearest-centroid search, one cell behind the update
    typedef struct packed {
        logic              valid;
        logic              final_feat;
        logic [CIDX_W-1:0] idx;
        logic [DIST_W-1:0] sq_dist;
        logic [CNT_W-1:0]  cnt;
    } t_min;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_ci;
        logic [IDX_W-1:0]  wr_fi;
        logic [VAL_W-1:0]  wr_val;
        logic              bump;
        logic [CIDX_W-1:0] bump_idx;
        logic              rep_load;
        logic              rep_shift;
        logic [CFG_W-1:0]  nc;
    } t_ctl;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

endpackage

// File: hw/rtl/kmeans_nearest_centroid_assign_unit.sv
// Top level of the k-means nearest-centroid assignment unit: sequencer, totals and cell row.
//
//  channel   dir  handshake                  payload
//  s_axis    in   i_s_axis_tvalid/o_..tready  tuser operation, tdata indices and value
//  m_axis    out  o_m_axis_tvalid/i_..tready  tuser kind, tlast last, tdata result fields
//  cfg       in   i_cfg_we                    i_cfg_index, i_cfg_data
//
//  A point feature runs down the row of MAX_CENTROIDS cells, one cell a cycle; the next word is
//  taken only once the last cell has finished its search. The last feature of a point then waits
//  for a free output register to place the result. Load and clear are taken without leaving idle.
//  A report gives one word per cycle unless the output stalls, MAX_CENTROIDS words at most.
//  Reset clears counts, totals and partial distances; the centroid store holds no reset.
//  Input is taken while a result waits in the output register; a stalled output holds
//  back the next result, and input waits until that result is placed.
module kmeans_nearest_centroid_assign_unit import knca_pkg::*; #(
    parameter int MAX_CENTROIDS = 16,
    parameter int MAX_FEATURES  = 16,
    parameter int VALUE_BITS    = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // centroid_index, feature_index, value
    input  logic [((2*IDX_W+VALUE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    // operation
    input  logic [1:0]                                   i_s_axis_tuser,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // cluster_index, distance, member_count, distance_sum, point_count
    output logic [OUT_W-1:0]                             o_m_axis_tdata,
    // kind
    output logic                                         o_m_axis_tuser,
    output logic                                         o_m_axis_tlast,
    input  logic                                         i_cfg_we,
    input  logic                                         i_cfg_index,
    input  logic [CFG_W-1:0]                             i_cfg_data
);

    localparam int N = MAX_CENTROIDS;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_cc, r_fc;
    logic [SUM_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_points;
    t_min              r_best;
    logic [CIDX_W-1:0] r_rep_idx;

    logic              r_out_valid;
    logic              r_o_kind;
    logic              r_o_last;
    logic [IDX_W-1:0]  r_o_idx;
    logic [DIST_W-1:0] r_o_dist;
    logic [CNT_W-1:0]  r_o_mc;
    logic [SUM_W-1:0]  r_o_ds;
    logic [CNT_W-1:0]  r_o_pc;

    logic [CFG_W-1:0]  w_nc, w_nf;
    t_op               w_op;
    logic [IDX_W-1:0]  w_ci, w_fi;
    logic [VALUE_BITS-1:0] w_val;
    logic              w_acc, w_feat_ok, w_out_free, w_rep_last;
    logic              w_load_assign, w_load_rep;
    logic [SUM_W:0]    w_sum_ext;
    logic [SUM_W-1:0]  n_total;
    logic [CNT_W-1:0]  n_points, n_cnt;
    t_tok              w_inject;
    t_ctl              w_ctl;

    t_tok              w_tok [N];
    t_min              w_min [N];
    logic [CNT_W-1:0]  w_rep [N];

    always_comb begin
        w_nc = r_cc;
        if (r_cc == '0) begin
            w_nc = CFG_W'(1);
        end else if (32'(r_cc) > 32'(MAX_CENTROIDS)) begin
            w_nc = CFG_W'(MAX_CENTROIDS);
        end
        w_nf = r_fc;
        if (r_fc == '0) begin
            w_nf = CFG_W'(1);
        end else if (32'(r_fc) > 32'(MAX_FEATURES)) begin
            w_nf = CFG_W'(MAX_FEATURES);
        end
    end

    assign w_op       = t_op'(i_s_axis_tuser);
    assign w_ci       = i_s_axis_tdata[IDX_W-1:0];
    assign w_fi       = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_val      = i_s_axis_tdata[2*IDX_W +: VALUE_BITS];
    assign w_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_feat_ok  = {1'b0, w_fi} < w_nf;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_rep_last = r_rep_idx == (w_nc - CFG_W'(1));

    assign w_sum_ext = {1'b0, r_total} + (SUM_W+1)'(r_best.sq_dist);
    assign n_total   = w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
    assign n_points  = sat_inc(r_points);
    assign n_cnt     = sat_inc(r_best.cnt);

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_load_assign   = 1'b0;
        w_load_rep      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (w_op == OP_FEATURE && w_feat_ok) begin
                        n_state = ST_RUN;
                    end else if (w_op == OP_REPORT) begin
                        n_state = ST_REP;
                    end
                end
            end
            ST_RUN: begin
                if (w_min[N-1].valid) begin
                    n_state = w_min[N-1].final_feat ? ST_PUT : ST_IDLE;
                end
            end
            ST_PUT: begin
                if (w_out_free) begin
                    w_load_assign = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_REP: begin
                if (w_out_free) begin
                    w_load_rep = 1'b1;
                    if (w_rep_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_inject.valid      = w_acc && w_op == OP_FEATURE && w_feat_ok;
        w_inject.first      = w_fi == '0;
        w_inject.final_feat = ({1'b0, w_fi} + CFG_W'(1)) == w_nf;
        w_inject.fi         = w_fi;
        w_inject.value      = VAL_W'(signed'(w_val));

        w_ctl.clear     = w_acc && w_op == OP_CLEAR;
        w_ctl.wr_en     = w_acc && w_op == OP_LOAD && (32'(w_fi) < 32'(MAX_FEATURES));
        w_ctl.wr_ci     = w_ci;
        w_ctl.wr_fi     = w_fi;
        w_ctl.wr_val    = VAL_W'(signed'(w_val));
        w_ctl.bump      = w_load_assign;
        w_ctl.bump_idx  = r_best.idx;
        w_ctl.rep_load  = w_acc && w_op == OP_REPORT;
        w_ctl.rep_shift = w_load_rep;
        w_ctl.nc        = w_nc;
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        t_tok             tok_in;
        t_min             min_in;
        logic [CNT_W-1:0] rep_in;

        if (k == 0) begin : g_first
            assign tok_in = w_inject;
            assign min_in = '0;
        end else begin : g_mid
            assign tok_in = w_tok[k-1];
            assign min_in = w_min[k-1];
        end

        if (k == N - 1) begin : g_end
            assign rep_in = '0;
        end else begin : g_next
            assign rep_in = w_rep[k+1];
        end

        knca_cell #(
            .K            (k),
            .VALUE_BITS   (VALUE_BITS),
            .MAX_FEATURES (MAX_FEATURES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (tok_in),
            .o_tok   (w_tok[k]),
            .i_min   (min_in),
            .o_min   (w_min[k]),
            .i_rep   (rep_in),
            .o_rep   (w_rep[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= CFG_W'(16);
            r_fc <= CFG_W'(16);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_CENTROID_COUNT) begin
                r_cc <= i_cfg_data;
            end else begin
                r_fc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_points <= '0;
        end else if (w_ctl.clear) begin
            r_total  <= '0;
            r_points <= '0;
        end else if (w_load_assign) begin
            r_total  <= n_total;
            r_points <= n_points;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && w_min[N-1].valid) begin
            r_best <= w_min[N-1];
        end
        if (w_ctl.rep_load) begin
            r_rep_idx <= '0;
        end else if (w_load_rep) begin
            r_rep_idx <= r_rep_idx + CIDX_W'(1);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_assign || w_load_rep) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_assign) begin
            r_o_kind <= KIND_ASSIGN;
            r_o_idx  <= r_best.idx[IDX_W-1:0];
            r_o_dist <= r_best.sq_dist;
            r_o_mc   <= n_cnt;
            r_o_ds   <= n_total;
            r_o_pc   <= n_points;
            r_o_last <= 1'b1;
        end else if (w_load_rep) begin
            r_o_kind <= KIND_REPORT;
            r_o_idx  <= r_rep_idx[IDX_W-1:0];
            r_o_dist <= '0;
            r_o_mc   <= w_rep[0];
            r_o_ds   <= r_total;
            r_o_pc   <= r_points;
            r_o_last <= w_rep_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {4'b0, r_o_pc, r_o_ds, r_o_mc, r_o_dist, r_o_idx};

endmodule

// File: hw/rtl/knca_cell.sv
// One centroid cell: store, squared-diff pipeline, partial distance, count, minimum, report.
module knca_cell import knca_pkg::*; #(
    parameter int K            = 0,
    parameter int VALUE_BITS   = 16,
    parameter int MAX_FEATURES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  t_tok             i_tok,
    output t_tok             o_tok,
    input  t_min             i_min,
    output t_min             o_min,
    input  logic [CNT_W-1:0] i_rep,
    output logic [CNT_W-1:0] o_rep
);

    localparam int FA = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam logic [7:0] K_ID = 8'(K);

    logic [VALUE_BITS-1:0] mem [MAX_FEATURES];

    t_tok r_tok, r_s1, r_s2, r_s3, r_s4;
    logic [VALUE_BITS-1:0] r_ce;
    logic [SQ_IN_W-1:0]    r_d;
    logic                  r_sat;
    logic [DIST_W-1:0]     r_sq;
    logic [DIST_W-1:0]     r_part;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_rep;
    t_min                  r_min;

    logic                     w_in_use;
    logic                     w_wr;
    logic [7:0]               w_wr_wide;
    logic [7:0]               w_rd_wide;
    logic signed [DIFF_W-1:0] w_a;
    logic signed [DIFF_W-1:0] w_b;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_mag;
    logic [DIST_W-1:0]        w_d_ext;
    logic [DIST_W-1:0]        w_base;
    logic [DIST_W:0]          w_acc;
    logic [DIST_W-1:0]        w_upd;
    logic                     w_take;

    assign w_in_use  = K_ID < {3'b0, i_ctl.nc};
    assign w_wr      = i_ctl.wr_en && ({4'b0, i_ctl.wr_ci} == K_ID);
    assign w_wr_wide = {4'b0, i_ctl.wr_fi};
    assign w_rd_wide = {4'b0, r_tok.fi};

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_wr_wide[FA-1:0]] <= i_ctl.wr_val[VALUE_BITS-1:0];
        end
        if (r_tok.valid) begin
            r_ce <= mem[w_rd_wide[FA-1:0]];
        end
    end

    always_comb begin
        w_a     = DIFF_W'(signed'(r_s1.value));
        w_b     = DIFF_W'(signed'(r_ce));
        w_diff  = w_a - w_b;
        w_mag   = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
        w_d_ext = DIST_W'(r_d);
        w_base  = r_s3.first ? '0 : r_part;
        w_acc   = {1'b0, w_base} + {1'b0, r_sq};
        w_upd   = w_acc[DIST_W] ? DIST_MAX : w_acc[DIST_W-1:0];
        w_take  = w_in_use && ((K == 0) || (r_part < i_min.sq_dist));
    end

    // token stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_s3.valid  <= 1'b0;
            r_s4.valid  <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_s1  <= r_tok;
            r_s2  <= r_s1;
            r_s3  <= r_s2;
            r_s4  <= r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= |w_mag[DIFF_W-1:SQ_IN_W];
        r_d   <= w_mag[SQ_IN_W-1:0];
        r_sq  <= r_sat ? DIST_MAX : w_d_ext * w_d_ext;
    end

    // partial distance: cleared by reset, by clear and after the assignment compare has passed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
        end else if (i_ctl.clear) begin
            r_part <= '0;
        end else if (r_s3.valid && w_in_use) begin
            r_part <= w_upd;
        end else if (r_s4.valid && r_s4.final_feat) begin
            r_part <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.clear) begin
            r_cnt <= '0;
        end else if (i_ctl.bump && ({3'b0, i_ctl.bump_idx} == K_ID)) begin
            r_cnt <= sat_inc(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rep_load) begin
            r_rep <= r_cnt;
        end else if (i_ctl.rep_shift) begin
            r_rep <= i_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min.valid <= 1'b0;
        end else begin
            r_min.valid      <= r_s4.valid;
            r_min.final_feat <= r_s4.final_feat;
            if (w_take) begin
                r_min.idx     <= CIDX_W'(K);
                r_min.sq_dist <= r_part;
                r_min.cnt     <= r_cnt;
            end else begin
                r_min.idx     <= i_min.idx;
                r_min.sq_dist <= i_min.sq_dist;
                r_min.cnt     <= i_min.cnt;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_min = r_min;
    assign o_rep = r_rep;

endmodule

// File: hw/rtl/knca_chk.sv
// Port-level checks of the assignment unit and the bind that attaches them.
module knca_chk import knca_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic [1:0]       i_s_axis_tuser,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tuser,
    input logic             o_m_axis_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed under stall");

    a_rep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_REPORT |=> !o_s_axis_tready)
        else $error("input taken right after a report request");

    a_rep_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_REPORT && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input taken before the report is complete");

    a_rep_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_REPORT |-> o_m_axis_tdata[DIST_W+IDX_W-1:IDX_W] == '0)
        else $error("report word with nonzero distance");

    a_assign_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_ASSIGN |-> o_m_axis_tlast)
        else $error("assignment word without last");

endmodule

bind kmeans_nearest_centroid_assign_unit knca_chk u_knca_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
